>>> src/ksel_pkg.sv
`timescale 1ns / 1ps
package ksel_pkg;
   localparam int MAX_ITEMS = 1024;
   localparam int DATA_W    = 32;
   localparam int RANK_W    = 10;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int CTR_W     = (CNT_W > RANK_W) ? CNT_W : RANK_W;

   typedef struct packed {
      logic clear;
      logic shift;
   } ksel_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DRAIN,
      ST_SHIFT,
      ST_FINISH
   } ksel_state_type;
endpackage

>>> src/ksel_cell.sv
`timescale 1ns / 1ps
module ksel_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  ksel_pkg::ksel_ctrl_type      ctrl,
   input  logic                         in_vld,
   input  logic signed [ksel_pkg::DATA_W-1:0] in_val,
   input  logic signed [ksel_pkg::DATA_W-1:0] right_val,
   output logic signed [ksel_pkg::DATA_W-1:0] held_val,
   output logic                         carry_vld,
   output logic signed [ksel_pkg::DATA_W-1:0] carry_val
);
   import ksel_pkg::*;

   logic signed [DATA_W-1:0] held_ff, held_in;
   logic signed [DATA_W-1:0] carry_ff, carry_in;
   logic                     occ_ff, occ_in;
   logic                     cvld_ff, cvld_in;

   always_comb begin
      held_in  = held_ff;
      carry_in = carry_ff;
      occ_in   = occ_ff;
      cvld_in  = 1'b0;
      if (ctrl.clear) begin
         occ_in = 1'b0;
      end else if (ctrl.shift) begin
         held_in = right_val;
      end else if (in_vld) begin
         if (!occ_ff) begin
            held_in = in_val;
            occ_in  = 1'b1;
         end else if (in_val < held_ff) begin
            held_in  = in_val;
            carry_in = held_ff;
            cvld_in  = 1'b1;
         end else begin
            carry_in = in_val;
            cvld_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= 1'b0;
         cvld_ff <= 1'b0;
      end else begin
         occ_ff  <= occ_in;
         cvld_ff <= cvld_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff  <= held_in;
      carry_ff <= carry_in;
   end

   assign held_val  = held_ff;
   assign carry_vld = cvld_ff;
   assign carry_val = carry_ff;
endmodule

>>> src/ksel_ctrl.sv
`timescale 1ns / 1ps
module ksel_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [ksel_pkg::RANK_W-1:0]  csr_wr_data,
   input  logic                         req_tvalid,
   input  logic                         req_tlast,
   output logic                         req_tready,
   output logic                         ins_en,
   output ksel_pkg::ksel_ctrl_type      ctrl,
   input  logic signed [ksel_pkg::DATA_W-1:0] head_val,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [ksel_pkg::DATA_W-1:0]  rsp_tdata,
   output logic                         rsp_tuser,
   output ksel_pkg::ksel_state_type     state,
   output logic [ksel_pkg::CNT_W-1:0]   count
);
   import ksel_pkg::*;

   ksel_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in, count_next;
   logic [CTR_W-1:0]  ctr_ff, ctr_in;
   logic [RANK_W-1:0] rank_ff;
   logic              err_ff, err_in;
   logic              rvld_ff, rvld_in;
   logic [DATA_W-1:0] rdata_ff, rdata_in;
   logic              ruser_ff, ruser_in;
   logic              accept;

   assign accept     = req_tvalid && req_tready;
   assign count_next = (count_ff < CNT_W'(MAX_ITEMS)) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ctr_in     = ctr_ff;
      err_in     = err_ff;
      rvld_in    = rvld_ff && !rsp_tready;
      rdata_in   = rdata_ff;
      ruser_in   = ruser_ff;
      ctrl       = '0;
      req_tready = 1'b0;
      ins_en     = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (accept) begin
               ins_en   = count_ff < CNT_W'(MAX_ITEMS);
               count_in = count_next;
               if (req_tlast) begin
                  ctr_in   = CTR_W'(count_next);
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (ctr_ff == '0) begin
               if (CTR_W'(rank_ff) >= CTR_W'(count_ff)) begin
                  err_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  ctr_in   = CTR_W'(rank_ff);
                  state_in = ST_SHIFT;
               end
            end else begin
               ctr_in = ctr_ff - 1'b1;
            end
         end
         ST_SHIFT: begin
            if (ctr_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               ctrl.shift = 1'b1;
               ctr_in     = ctr_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rvld_ff || rsp_tready) begin
               rvld_in    = 1'b1;
               rdata_in   = err_ff ? '0 : head_val;
               ruser_in   = err_ff;
               err_in     = 1'b0;
               count_in   = '0;
               ctrl.clear = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ctr_ff   <= '0;
         err_ff   <= 1'b0;
         rvld_ff  <= 1'b0;
         rank_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ctr_ff   <= ctr_in;
         err_ff   <= err_in;
         rvld_ff  <= rvld_in;
         if (csr_wr_en) begin
            rank_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= rdata_in;
      ruser_ff <= ruser_in;
   end

   assign rsp_tvalid = rvld_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = ruser_ff;
   assign state      = state_ff;
   assign count      = count_ff;
endmodule

>>> src/kth_smallest_select_unit.sv
`timescale 1ns / 1ps
// Words stream in one per cycle while the unit is loading (req_tready high) and drop
// into a row of sorting cells, each holding one value and passing the larger of its
// value and the arriving one to its neighbor, so the row stays in ascending order. A
// word with tlast closes the set of n words (n = words stored, at most 1024): the unit
// then waits for the carries to ripple down the cell row, shifts the row toward the
// head rank times, and returns the head value, or zero with the error flag when rank
// is not below n. The result is loaded only once the output register is free of the
// previous one; no input is taken from the tlast word until the result is in the
// output register. Words beyond 1024 in one set are dropped.
module kth_smallest_select_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [ksel_pkg::RANK_W-1:0] csr_wr_data,     // target_rank
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ksel_pkg::DATA_W-1:0] req_tdata,       // sample_value
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ksel_pkg::DATA_W-1:0] rsp_tdata,       // selected_value
   output logic                        rsp_tuser        // rank_error
);
   import ksel_pkg::*;

   ksel_ctrl_type            ctrl;
   ksel_state_type           state;
   logic [CNT_W-1:0]         count;
   logic                     ins_en;
   logic signed [DATA_W-1:0] held_w  [MAX_ITEMS];
   logic signed [DATA_W-1:0] carry_w [MAX_ITEMS];
   logic                     cvld_w  [MAX_ITEMS];

   ksel_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tlast   (req_tlast),
      .req_tready  (req_tready),
      .ins_en      (ins_en),
      .ctrl        (ctrl),
      .head_val    (held_w[0]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .state       (state),
      .count       (count)
   );

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic                     c_in_vld;
      logic signed [DATA_W-1:0] c_in_val;
      logic signed [DATA_W-1:0] c_right;
      if (i == 0) begin : g_head
         assign c_in_vld = ins_en;
         assign c_in_val = $signed(req_tdata);
      end else begin : g_body
         assign c_in_vld = cvld_w[i-1];
         assign c_in_val = carry_w[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_tail
         assign c_right = held_w[i];
      end else begin : g_mid
         assign c_right = held_w[i+1];
      end
      ksel_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .in_vld    (c_in_vld),
         .in_val    (c_in_val),
         .right_val (c_right),
         .held_val  (held_w[i]),
         .carry_vld (cvld_w[i]),
         .carry_val (carry_w[i])
      );
   end

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("rank error word carries nonzero data");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken right after last word");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count <= CNT_W'(MAX_ITEMS))
      else $error("stored count beyond capacity");

   a_ready_load: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state == ST_LOAD)
      else $error("ready outside load phase");
endmodule
